// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// Each macro takes a label, a clock and the property terms; all but ASSERT_NEXT_ALWAYS also take an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked while reset is applied.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication under reset");

`endif

// ===== design/bssc_pkg.sv =====
// Package for the bit store with set-bit scan: sizes, request codes and shared types.
// Used by the top level, the lowest-set-bit unit, the checker and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bssc_pkg;

    localparam int STORE_BYTES    = 128;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int MAX_SCAN_BYTES = 8;
    localparam int BYTE_W         = 8;
    localparam int BIT_IDX_W      = 10;
    localparam int CNT_W          = 4;
    localparam int REQ_W          = 3;
    localparam int S_TDATA_W      = 32;
    localparam int M_TDATA_W      = 24;
    localparam int M_PAD_W        = M_TDATA_W - 1 - BYTE_W - BIT_IDX_W;

    localparam logic [REQ_W-1:0] REQ_TEST  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SCAN  = 3'd4;

    typedef struct packed {
        logic       any;
        logic [2:0] pos;
        logic [7:0] rest;
    } lsb_info_t;

endpackage

`default_nettype wire

// ===== design/bitset_store_with_set_bit_scan.sv =====
// Test, set, clear and write read their byte on acceptance and end in ST_BITOP: a write-back,
// or for a test a result into the output register once that register is free. A scan gives
// each byte a fetch, a load and one lowest-set-bit pass per set bit plus one to see it empty.
// After reset a clearing pass writes zero to all STORE_BYTES bytes, one per cycle,
// and no item is accepted until it ends. The output register frees the sequencer from the sink.
`timescale 1ns / 1ps
`default_nettype none

module bitset_store_with_set_bit_scan #(
    parameter int MAX_SCAN_BYTES = bssc_pkg::MAX_SCAN_BYTES
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // bit_index[9:0], bit_value[10], start_byte[17:11], byte_count[21:18], index_base[31:22]
    input  wire logic [bssc_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[2:0]
    input  wire logic [bssc_pkg::REQ_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // test_result[0], bit_weight[8:1], found_index[18:9], zero padding[23:19]
    output logic      [bssc_pkg::M_TDATA_W-1:0] m_tdata,
    // found[0]
    output logic                                m_tuser,
    output logic                                m_tlast
);

    localparam int AW  = bssc_pkg::ADDR_W;
    localparam int CW  = bssc_pkg::CNT_W;
    localparam int IW  = bssc_pkg::BIT_IDX_W;
    localparam int BW  = bssc_pkg::BYTE_W;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_BITOP  = 7'b0000100,
        ST_FETCH  = 7'b0001000,
        ST_LOAD   = 7'b0010000,
        ST_SCAN   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            clr_addr_reg, clr_addr_next;
    logic [bssc_pkg::REQ_W-1:0] req_reg, req_next;
    logic [AW-1:0]            addr_reg, addr_next;
    logic [2:0]               bitpos_reg, bitpos_next;
    logic                     bval_reg, bval_next;
    logic [CW-1:0]            n_reg, n_next;
    logic [CW-1:0]            off_reg, off_next;
    logic [IW-1:0]            base_reg, base_next;
    logic [BW-1:0]            work_reg, work_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [IW-1:0]            pend_idx_reg, pend_idx_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     out_test_reg, out_test_next;
    logic [BW-1:0]            out_weight_reg, out_weight_next;
    logic [IW-1:0]            out_index_reg, out_index_next;
    logic                     out_found_reg, out_found_next;
    logic                     out_last_reg, out_last_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [BW-1:0]            ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [BW-1:0]            ram_rdata;

    bssc_pkg::lsb_info_t      lsb_info;

    logic [bssc_pkg::REQ_W-1:0] in_req;
    logic [IW-1:0]            in_bit_index;
    logic                     in_bit_value;
    logic [AW-1:0]            in_start_byte;
    logic [CW-1:0]            in_byte_count;
    logic [IW-1:0]            in_index_base;
    logic [CW-1:0]            scan_len;
    logic                     accept;
    logic                     out_free;
    logic [BW-1:0]            mask;
    logic [BW-1:0]            weight;

    assign in_req        = s_tuser;
    assign in_bit_index  = s_tdata[9:0];
    assign in_bit_value  = s_tdata[10];
    assign in_start_byte = s_tdata[17:11];
    assign in_byte_count = s_tdata[21:18];
    assign in_index_base = s_tdata[31:22];

    assign scan_len = (in_byte_count > CW'(MAX_SCAN_BYTES)) ? CW'(MAX_SCAN_BYTES)
                                                            : in_byte_count;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign mask     = BW'(1) << bitpos_reg;
    assign weight   = ram_rdata & mask;

    bssc_ram #(
        .WIDTH (BW),
        .DEPTH (bssc_pkg::STORE_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bssc_lsb_unit u_lsb (
        .data_in (work_reg),
        .info    (lsb_info)
    );

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        bitpos_next     = bitpos_reg;
        bval_next       = bval_reg;
        n_next          = n_reg;
        off_next        = off_reg;
        base_next       = base_reg;
        work_next       = work_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_test_next   = out_test_reg;
        out_weight_next = out_weight_reg;
        out_index_next  = out_index_reg;
        out_found_next  = out_found_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = in_bit_index[IW-1:3];

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(bssc_pkg::STORE_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    req_next        = in_req;
                    bitpos_next     = in_bit_index[2:0];
                    bval_next       = in_bit_value;
                    base_next       = in_index_base;
                    n_next          = scan_len;
                    off_next        = '0;
                    pend_valid_next = 1'b0;
                    if (in_req == bssc_pkg::REQ_SCAN) begin
                        addr_next  = in_start_byte;
                        state_next = ST_FETCH;
                    end else if (in_req <= bssc_pkg::REQ_WRITE) begin
                        addr_next  = in_bit_index[IW-1:3];
                        ram_re     = 1'b1;
                        state_next = ST_BITOP;
                    end
                end
            end
            ST_BITOP: begin
                if (req_reg == bssc_pkg::REQ_TEST) begin
                    if (out_free) begin
                        m_valid_next    = 1'b1;
                        out_test_next   = |weight;
                        out_weight_next = weight;
                        out_index_next  = '0;
                        out_found_next  = 1'b0;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                    if ((req_reg == bssc_pkg::REQ_SET) ||
                        ((req_reg == bssc_pkg::REQ_WRITE) && bval_reg)) begin
                        ram_wdata = ram_rdata | mask;
                    end else begin
                        ram_wdata = ram_rdata & ~mask;
                    end
                end
            end
            ST_FETCH: begin
                if (off_reg == n_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = addr_reg + AW'(off_reg);
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                work_next  = ram_rdata;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (!lsb_info.any) begin
                    off_next   = off_reg + CW'(1);
                    state_next = ST_FETCH;
                end else if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next    = 1'b1;
                        out_test_next   = 1'b0;
                        out_weight_next = '0;
                        out_index_next  = pend_idx_reg;
                        out_found_next  = 1'b1;
                        out_last_next   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_idx_next   = base_reg + IW'({off_reg[2:0], lsb_info.pos});
                    work_next       = lsb_info.rest;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_test_next   = 1'b0;
                    out_weight_next = '0;
                    out_index_next  = pend_valid_reg ? pend_idx_reg : '0;
                    out_found_next  = pend_valid_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        bitpos_reg     <= bitpos_next;
        bval_reg       <= bval_next;
        n_reg          <= n_next;
        off_reg        <= off_next;
        base_reg       <= base_next;
        work_reg       <= work_next;
        pend_idx_reg   <= pend_idx_next;
        out_test_reg   <= out_test_next;
        out_weight_reg <= out_weight_next;
        out_index_reg  <= out_index_next;
        out_found_reg  <= out_found_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{bssc_pkg::M_PAD_W{1'b0}}, out_index_reg, out_weight_reg, out_test_reg};
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== design/bssc_ram.sv =====
// Generic memory with one write port and one registered read port.
// Standalone; used for the byte store of the block.
`timescale 1ns / 1ps
`default_nettype none

module bssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/bssc_lsb_unit.sv =====
// Lowest-set-bit unit: position of the lowest one in a byte and the byte without it.
// Depends on bssc_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module bssc_lsb_unit (
    input  wire logic [7:0]          data_in,
    output bssc_pkg::lsb_info_t      info
);

    logic [2:0] pos;

    always_comb begin
        pos = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (data_in[i]) begin
                pos = 3'(i);
            end
        end
    end

    assign info.any  = |data_in;
    assign info.pos  = pos;
    assign info.rest = data_in & (data_in - 8'd1);

endmodule

`default_nettype wire

// ===== design/bssc_checker.sv =====
// Port-level checker for the bit store with set-bit scan, bound to the top level.
// Depends on bssc_pkg and the macros in assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bssc_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [bssc_pkg::REQ_W-1:0]     s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [bssc_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tuser,
    input wire logic                           m_tlast
);

    logic                           out_wait;
    logic                           known_accept;
    logic                           weight_ok;
    logic [bssc_pkg::M_TDATA_W+1:0] out_bus;

    // Undefined request codes are dropped in the accepting cycle, so only known ones occupy the block.
    assign out_wait     = m_tvalid && !m_tready;
    assign known_accept = s_tvalid && s_tready && (s_tuser <= bssc_pkg::REQ_SCAN);
    assign weight_ok    = $onehot0(m_tdata[8:1]) && (m_tdata[0] == (m_tdata[8:1] != 8'd0));
    assign out_bus      = {m_tdata, m_tuser, m_tlast};

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, out_wait, m_tvalid && $stable(out_bus))

    `ASSERT_NEXT_ALWAYS(a_reset_blocks_input, aclk, !aresetn, !s_tready)

    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, known_accept, !s_tready)

    `ASSERT_IMPLY(a_empty_scan_is_last, aclk, aresetn, m_tvalid && !m_tuser, m_tlast)

    `ASSERT_IMPLY(a_weight_consistent, aclk, aresetn, m_tvalid, weight_ok)

endmodule

bind bitset_store_with_set_bit_scan bssc_checker u_bssc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for bitset_store_with_set_bit_scan: directed and random traffic
// with bursty input, random output stalls and one long output hold-off.
// Depends on bssc_pkg and the block itself.
`timescale 1ns / 1ps

module tb_top;
    import bssc_pkg::*;

    typedef struct packed {
        logic                 test_result;
        logic [BYTE_W-1:0]    bit_weight;
        logic [BIT_IDX_W-1:0] found_index;
        logic                 found;
        logic                 last;
    } result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [REQ_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    logic [BYTE_W-1:0] store_model [0:STORE_BYTES-1];
    result_t           pending_results[$];
    int                mismatch_count = 0;
    int                burst_left = 0;
    int                max_gap = 3;
    int                pattern_left = 0;
    int                stall_pct = 0;
    int                hold_left = 0;
    int                holds_requested = 0;
    int                holds_served = 0;

    bitset_store_with_set_bit_scan u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Expected results of one accepted item, computed against the model store.
    function automatic void apply_request(logic [REQ_W-1:0] req, logic [BIT_IDX_W-1:0] bidx,
                                          logic bval, logic [ADDR_W-1:0] sbyte,
                                          logic [CNT_W-1:0] cnt, logic [BIT_IDX_W-1:0] base);
        logic [ADDR_W-1:0]    addr;
        logic [BYTE_W-1:0]    mask;
        logic [BYTE_W-1:0]    bits;
        logic [BIT_IDX_W-1:0] idx;
        result_t              res;
        int                   n;
        int                   hits;
        addr = ADDR_W'(bidx[BIT_IDX_W-1:3] % STORE_BYTES);
        mask = 8'd1 << bidx[2:0];
        res = '0;
        case (req)
            REQ_TEST: begin
                res.bit_weight = store_model[addr] & mask;
                res.test_result = |res.bit_weight;
                res.last = 1'b1;
                pending_results.push_back(res);
            end
            REQ_SET: store_model[addr] = store_model[addr] | mask;
            REQ_CLEAR: store_model[addr] = store_model[addr] & ~mask;
            REQ_WRITE: begin
                if (bval) begin
                    store_model[addr] = store_model[addr] | mask;
                end else begin
                    store_model[addr] = store_model[addr] & ~mask;
                end
            end
            REQ_SCAN: begin
                n = (cnt > MAX_SCAN_BYTES) ? MAX_SCAN_BYTES : int'(cnt);
                hits = 0;
                for (int off = 0; off < n; off++) begin
                    bits = store_model[(sbyte + off) % STORE_BYTES];
                    for (int b = 0; b < BYTE_W; b++) begin
                        if (bits[b]) begin
                            idx = BIT_IDX_W'((base + off * 8 + b) % (STORE_BYTES * 8));
                            res = '0;
                            res.found_index = idx;
                            res.found = 1'b1;
                            pending_results.push_back(res);
                            hits++;
                        end
                    end
                end
                if (hits == 0) begin
                    res = '0;
                    res.last = 1'b1;
                    pending_results.push_back(res);
                end else begin
                    pending_results[$].last = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // Offers one item from a falling edge until it is taken, then maybe opens a gap.
    task automatic send_request(logic [REQ_W-1:0] req, logic [BIT_IDX_W-1:0] bidx, logic bval,
                                logic [ADDR_W-1:0] sbyte, logic [CNT_W-1:0] cnt,
                                logic [BIT_IDX_W-1:0] base);
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {base, cnt, sbyte, bval, bidx};
        do @(posedge aclk); while (!s_tready);
        apply_request(req, bidx, bval, sbyte, cnt, base);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            if (max_gap > 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, max_gap)) @(negedge aclk);
            end
        end
    endtask

    task automatic send_bit_op(logic [REQ_W-1:0] req, logic [BIT_IDX_W-1:0] bidx, logic bval);
        send_request(req, bidx, bval, ADDR_W'($urandom), CNT_W'($urandom),
                     BIT_IDX_W'($urandom));
    endtask

    task automatic send_scan(logic [ADDR_W-1:0] sbyte, logic [CNT_W-1:0] cnt,
                             logic [BIT_IDX_W-1:0] base);
        send_request(REQ_SCAN, BIT_IDX_W'($urandom), 1'($urandom), sbyte, cnt, base);
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic test_cleared_store();
        send_bit_op(REQ_TEST, 10'd0, 1'b1);
        send_bit_op(REQ_TEST, 10'd1023, 1'b0);
        send_scan(7'd0, 4'd8, 10'd0);
        send_scan(7'd127, 4'd0, 10'd1023);
    endtask

    task automatic test_single_bit_ops();
        send_bit_op(REQ_SET, 10'd0, 1'b0);
        send_bit_op(REQ_SET, 10'd1023, 1'b0);
        send_bit_op(REQ_WRITE, 10'd7, 1'b1);
        send_bit_op(REQ_TEST, 10'd0, 1'b0);
        send_bit_op(REQ_TEST, 10'd1023, 1'b1);
        send_bit_op(REQ_TEST, 10'd7, 1'b0);
        send_bit_op(REQ_WRITE, 10'd1023, 1'b0);
        send_bit_op(REQ_TEST, 10'd1023, 1'b0);
        send_bit_op(REQ_CLEAR, 10'd0, 1'b1);
        send_bit_op(REQ_TEST, 10'd0, 1'b1);
        // Undefined request codes must leave the store alone.
        send_bit_op(3'd5, 10'd8, 1'b1);
        send_bit_op(3'd6, 10'd9, 1'b1);
        send_bit_op(3'd7, 10'd10, 1'b1);
    endtask

    task automatic test_scan_wrap_and_saturate();
        send_bit_op(REQ_SET, 10'd1016, 1'b0);
        send_bit_op(REQ_SET, 10'd3, 1'b0);
        send_bit_op(REQ_WRITE, 10'd15, 1'b1);
        send_scan(7'd127, 4'd15, 10'd1020);
        send_scan(7'd127, 4'd2, 10'd0);
        send_scan(7'd2, 4'd8, 10'd512);
    endtask

    // Fills eight bytes, then holds the output off while full scans keep arriving.
    task automatic test_full_scan_backpressure();
        max_gap = 0;
        for (int i = 0; i < 64; i++) begin
            send_bit_op(REQ_SET, BIT_IDX_W'(320 + i), 1'($urandom));
        end
        holds_requested++;
        for (int i = 0; i < 4; i++) begin
            send_scan(7'd40, 4'd8, BIT_IDX_W'($urandom));
            send_bit_op(REQ_TEST, BIT_IDX_W'(320 + $urandom_range(0, 63)), 1'($urandom));
        end
        wait_until_drained();
    endtask

    task automatic test_random_traffic(int item_total);
        int                   counted;
        int                   pick;
        logic [ADDR_W-1:0]    hot_byte;
        logic [BIT_IDX_W-1:0] bidx;
        logic [ADDR_W-1:0]    sbyte;
        logic [CNT_W-1:0]     cnt;
        counted = 0;
        hot_byte = ADDR_W'($urandom);
        while (counted < item_total) begin
            if (counted % 30 == 0) begin
                hot_byte = ADDR_W'($urandom);
                max_gap = $urandom_range(0, 6);
            end
            if ($urandom_range(0, 99) < 70) begin
                bidx = {hot_byte + 7'($urandom_range(0, 3)), 3'($urandom)};
            end else begin
                bidx = BIT_IDX_W'($urandom);
            end
            if ($urandom_range(0, 99) < 70) begin
                sbyte = hot_byte - 7'($urandom_range(0, 2));
            end else begin
                sbyte = ADDR_W'($urandom);
            end
            if ($urandom_range(0, 99) < 85) begin
                cnt = CNT_W'($urandom_range(1, MAX_SCAN_BYTES));
            end else begin
                cnt = CNT_W'($urandom);
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                send_bit_op(REQ_TEST, bidx, 1'($urandom));
            end else if (pick < 50) begin
                send_bit_op(REQ_SET, bidx, 1'($urandom));
            end else if (pick < 60) begin
                send_bit_op(REQ_CLEAR, bidx, 1'($urandom));
            end else if (pick < 75) begin
                send_bit_op(REQ_WRITE, bidx, 1'($urandom));
            end else if (pick < 95) begin
                send_scan(sbyte, cnt, BIT_IDX_W'($urandom));
            end else begin
                send_bit_op(REQ_W'($urandom_range(5, 7)), BIT_IDX_W'($urandom), 1'($urandom));
                counted--;
            end
            counted++;
        end
        wait_until_drained();
    endtask

    always @(negedge aclk) begin
        if (pattern_left == 0) begin
            pattern_left = $urandom_range(10, 60);
            case ($urandom_range(0, 4))
                0, 1: stall_pct = 0;
                2: stall_pct = 30;
                3: stall_pct = 60;
                default: stall_pct = 85;
            endcase
        end else begin
            pattern_left--;
        end
        if (holds_served != holds_requested) begin
            holds_served = holds_requested;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[8:1], m_tdata[18:9], m_tuser, m_tlast};
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected item, expected none, actual %h", $time, got);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("test_result", 32'(want.test_result), 32'(got.test_result));
                check_field("bit_weight", 32'(want.bit_weight), 32'(got.bit_weight));
                check_field("found_index", 32'(want.found_index), 32'(got.found_index));
                check_field("found", 32'(want.found), 32'(got.found));
                check_field("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    initial begin
        for (int i = 0; i < STORE_BYTES; i++) begin
            store_model[i] = '0;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_cleared_store();
        test_single_bit_ops();
        test_scan_wrap_and_saturate();
        wait_until_drained();
        test_full_scan_backpressure();
        test_random_traffic(120);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
